// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the line tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i while rst_ni is released.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_AT(label, !(cond), msg)

`endif

// ===== design/alt_pkg.sv =====
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types, constants and helper functions of the assembly line tokenizer.
// ----------------------------------------------------------------------------
package alt_pkg;

  // Size of the downstream token buffer; a token holds at most one less.
  localparam int unsigned TokenBuf   = 64;
  localparam int unsigned LenW       = 6;
  localparam int unsigned LimitCapI  = (TokenBuf - 1 < 63) ? TokenBuf - 1 : 63;
  localparam logic [LenW-1:0] LimitCap = LenW'(LimitCapI);

  localparam logic [LenW-1:0] MaxTokenLenReset = 6'd63;

  // Register indexes of the configuration port.
  localparam logic RegMaxTokenLen = 1'b0;

  // Field codes.
  localparam logic [1:0] FieldLabel  = 2'd0;
  localparam logic [1:0] FieldOpcode = 2'd1;
  localparam logic [1:0] FieldOp2    = 2'd3;

  // Characters with a special role.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChLBrk  = 8'h5B;
  localparam logic [7:0] ChRBrk  = 8'h5D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChUnder = 8'h5F;

  // One result item.
  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] field;
    logic       char_valid;
    logic       token_end;
    logic       line_end;
    logic       label_error;
  } result_t;

  // Length limit in force: at least one, at most the buffer capacity.
  function automatic logic [LenW-1:0] token_limit(input logic [LenW-1:0] max_len);
    logic [LenW-1:0] l;
    l = (max_len == '0) ? LenW'(1) : max_len;
    if (l > LimitCap) l = LimitCap;
    return l;
  endfunction

endpackage

// ===== design/asm_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// asm_line_tokenizer_unit
// Splits assembly source lines, one character per transfer, into label,
// opcode and two operand fields.
// ----------------------------------------------------------------------------
// Usage: characters arrive on the input channel (in_valid_i, in_ready_o,
// ch_i), one per transfer. Each character is held in an input register and
// classified against the scan state once the output register can take its
// result; a character that produces a result is written to the output
// register, which drives the result channel (out_valid_o, out_ready_i and
// the six result ports). Characters that produce no result (separators,
// skipped text) retire silently. A result passes the input register, then
// the output register. Throughput is one character per cycle unless the
// receiver stalls: the only loop is the scan state, updated by short
// classification logic. When the receiver stalls with a result pending,
// the input register keeps one more character and in_ready_o drops until
// the result is taken. Reset clears both pipeline valid flags, returns the
// scanner to the line start in the label field and sets max_token_len to
// 63. The APB port (one register at byte address 0) must be written only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asm_line_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic [1:0]  field_o,
  output logic        char_valid_o,
  output logic        token_end_o,
  output logic        line_end_o,
  output logic        label_error_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                     in_valid_q, in_valid_d;
  logic [7:0]               ch_q;
  logic                     out_valid_q, out_valid_d;
  alt_pkg::result_t         res_q;
  alt_pkg::result_t         step_res;
  logic                     step_has_res;
  logic                     advance;
  logic [alt_pkg::LenW-1:0] max_token_len;

  alt_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_token_len_o (max_token_len)
  );

  // The held character is processed once the output register can take its
  // result, whether or not the character actually produces one.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  alt_scan_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .ch_i            (ch_q),
    .max_token_len_i (max_token_len),
    .has_result_o    (step_has_res),
    .result_o        (step_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) in_valid_d = in_valid_i;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step_has_res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) ch_q <= ch_i;
    if (advance && step_has_res) res_q <= step_res;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = res_q.out_char;
  assign field_o       = res_q.field;
  assign char_valid_o  = res_q.char_valid;
  assign token_end_o   = res_q.token_end;
  assign line_end_o    = res_q.line_end;
  assign label_error_o = res_q.label_error;

  `ASSERT_AT(a_result_has_flag,
    out_valid_o |-> (char_valid_o || token_end_o || line_end_o || label_error_o),
    "result transfer without any flag set")
  `ASSERT_NEVER(a_label_error_alone,
    out_valid_o && label_error_o && (token_end_o || char_valid_o),
    "label error combined with token end or character")
  `ASSERT_AT(a_stall_blocks_input,
    (in_valid_q && out_valid_o && !out_ready_i) |-> !in_ready_o,
    "input taken while held character cannot retire")

endmodule

// ===== design/alt_apb_regs.sv =====
// ----------------------------------------------------------------------------
// alt_apb_regs
// APB register file holding the token length limit.
// ----------------------------------------------------------------------------
module alt_apb_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [alt_pkg::LenW-1:0]  max_token_len_o
);

  logic [alt_pkg::LenW-1:0] max_len_q, max_len_d;
  logic                     hit;

  // Word address selects the register; only one register exists.
  assign hit   = (paddr[2] == alt_pkg::RegMaxTokenLen);
  assign pready = 1'b1;

  always_comb begin
    max_len_d = max_len_q;
    if (psel && penable && pwrite && hit) begin
      max_len_d = pwdata[alt_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= alt_pkg::MaxTokenLenReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign prdata          = hit ? {{(32 - alt_pkg::LenW){1'b0}}, max_len_q} : 32'h0;
  assign max_token_len_o = max_len_q;

endmodule

// ===== design/alt_scan_core.sv =====
// ----------------------------------------------------------------------------
// alt_scan_core
// Scan state machine: classifies one character and updates field state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alt_scan_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                ch_i,
  input  logic [alt_pkg::LenW-1:0]  max_token_len_i,
  output logic                      has_result_o,
  output alt_pkg::result_t          result_o
);

  typedef enum logic [4:0] {
    MODE_LINE_START = 5'b00001,
    MODE_BETWEEN    = 5'b00010,
    MODE_IN_TOKEN   = 5'b00100,
    MODE_FULL       = 5'b01000,
    MODE_SKIP       = 5'b10000
  } scan_mode_e;

  scan_mode_e               mode_q, mode_d;
  logic [1:0]               field_q, field_d;
  logic [alt_pkg::LenW-1:0] tlen_q, tlen_d;
  logic [alt_pkg::LenW-1:0] lim;
  logic [alt_pkg::LenW-1:0] tlen_inc;
  logic                     eol, tok, semi, colon, full;
  alt_pkg::result_t         res;

  assign lim      = alt_pkg::token_limit(max_token_len_i);
  assign tlen_inc = tlen_q + alt_pkg::LenW'(1);

  assign eol   = (ch_i == alt_pkg::ChNul) || (ch_i == alt_pkg::ChLf) ||
                 (ch_i == alt_pkg::ChCr);
  assign semi  = (ch_i == alt_pkg::ChSemi);
  assign colon = (ch_i == alt_pkg::ChColon);
  assign tok   = (ch_i >= 8'h61 && ch_i <= 8'h7A) || (ch_i >= 8'h41 && ch_i <= 8'h5A) ||
                 (ch_i >= 8'h30 && ch_i <= 8'h39) || (ch_i == alt_pkg::ChUnder) ||
                 (ch_i == alt_pkg::ChLBrk) || (ch_i == alt_pkg::ChRBrk) ||
                 (ch_i == alt_pkg::ChPlus) || (ch_i == alt_pkg::ChMinus);
  assign full  = (mode_q == MODE_FULL) || (tlen_q >= lim);

  always_comb begin
    res     = '0;
    mode_d  = mode_q;
    field_d = field_q;
    tlen_d  = tlen_q;
    unique case (mode_q) inside
      MODE_LINE_START: begin
        if (eol) begin
          res.line_end = 1'b1;
        end else if (tok) begin
          res.out_char   = ch_i;
          res.field      = alt_pkg::FieldLabel;
          res.char_valid = 1'b1;
          field_d        = alt_pkg::FieldLabel;
          tlen_d         = alt_pkg::LenW'(1);
          mode_d         = (lim == alt_pkg::LenW'(1)) ? MODE_FULL : MODE_IN_TOKEN;
        end else if (semi) begin
          mode_d = MODE_SKIP;
        end else begin
          // Empty label: go on with the opcode field.
          field_d = alt_pkg::FieldOpcode;
          mode_d  = MODE_BETWEEN;
        end
      end
      MODE_BETWEEN: begin
        if (eol) begin
          res.field    = field_q;
          res.line_end = 1'b1;
          field_d      = alt_pkg::FieldLabel;
          tlen_d       = '0;
          mode_d       = MODE_LINE_START;
        end else if (tok) begin
          res.out_char   = ch_i;
          res.field      = field_q;
          res.char_valid = 1'b1;
          tlen_d         = alt_pkg::LenW'(1);
          mode_d         = (lim == alt_pkg::LenW'(1)) ? MODE_FULL : MODE_IN_TOKEN;
        end else if (semi) begin
          mode_d = MODE_SKIP;
        end
      end
      MODE_IN_TOKEN, MODE_FULL: begin
        if (field_q == alt_pkg::FieldLabel && !(tok && !full)) begin
          if (colon) begin
            res.token_end = 1'b1;
            field_d       = alt_pkg::FieldOpcode;
            tlen_d        = '0;
            mode_d        = MODE_BETWEEN;
          end else begin
            // Label without its colon: flag it and drop the rest of the line.
            res.label_error = 1'b1;
            res.line_end    = eol;
            tlen_d          = '0;
            mode_d          = eol ? MODE_LINE_START : MODE_SKIP;
          end
        end else if (tok && !full) begin
          res.out_char   = ch_i;
          res.field      = field_q;
          res.char_valid = 1'b1;
          tlen_d         = tlen_inc;
          if (tlen_inc >= lim) mode_d = MODE_FULL;
        end else if (tok) begin
          // Full token: the character opens the next field; after op2 the line is skipped.
          if (field_q == alt_pkg::FieldOp2) begin
            res.field     = alt_pkg::FieldOp2;
            res.token_end = 1'b1;
            tlen_d        = '0;
            mode_d        = MODE_SKIP;
          end else begin
            res.out_char   = ch_i;
            res.field      = field_q + 2'd1;
            res.char_valid = 1'b1;
            res.token_end  = 1'b1;
            field_d        = field_q + 2'd1;
            tlen_d         = alt_pkg::LenW'(1);
            mode_d         = (lim == alt_pkg::LenW'(1)) ? MODE_FULL : MODE_IN_TOKEN;
          end
        end else begin
          res.field     = field_q;
          res.token_end = 1'b1;
          res.line_end  = eol;
          tlen_d        = '0;
          if (eol) begin
            field_d = alt_pkg::FieldLabel;
            mode_d  = MODE_LINE_START;
          end else if (semi || field_q == alt_pkg::FieldOp2) begin
            mode_d = MODE_SKIP;
          end else begin
            field_d = field_q + 2'd1;
            mode_d  = MODE_BETWEEN;
          end
        end
      end
      default: begin
        // Skip to the end of the line.
        if (eol) begin
          res.field    = field_q;
          res.line_end = 1'b1;
          field_d      = alt_pkg::FieldLabel;
          tlen_d       = '0;
          mode_d       = MODE_LINE_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINE_START;
      field_q <= alt_pkg::FieldLabel;
      tlen_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      field_q <= field_d;
      tlen_q  <= tlen_d;
    end
  end

  assign result_o     = res;
  assign has_result_o = res.char_valid | res.token_end | res.line_end | res.label_error;

  `ASSERT_AT(a_line_start_clean,
    (mode_q == MODE_LINE_START) |-> (field_q == alt_pkg::FieldLabel && tlen_q == '0),
    "line start mode with stale field or length")
  `ASSERT_AT(a_idle_len_zero,
    (mode_q == MODE_BETWEEN || mode_q == MODE_SKIP) |-> (tlen_q == '0),
    "token length kept outside a token")
  `ASSERT_NEVER(a_token_len_nonzero,
    (mode_q == MODE_IN_TOKEN || mode_q == MODE_FULL) && (tlen_q == '0),
    "inside a token with zero length")

endmodule
